// ===== sv/ppu_pkg.sv =====
package ppu_pkg;

    localparam int unsigned TW_N = 624;
    localparam int unsigned TW_M = 397;
    localparam logic [9:0]  TW_LAST = 10'd623;
    localparam logic [9:0]  TW_WRAP = 10'd227;
    localparam logic [9:0]  TW_STEP = 10'd397;
    localparam logic [31:0] TW_SEED = 32'd5489;
    localparam logic [31:0] TW_MULT = 32'd1812433253;
    localparam logic [31:0] TW_MAG  = 32'h9908_B0DF;

    // 0.1/pi * 2^32: angle turns per Q16.16 time unit
    localparam logic [31:0] TURN_PER_TIME = 32'd136713055;
    localparam logic [16:0] Q_ONE = 17'h1_0000;
    localparam logic [2:0]  MIX_LAST = 3'd5;

    typedef enum logic [1:0] {
        MODE_EMIT   = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_RENDER = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_SPREAD_X = 2'd0,
        REG_SPREAD_Y = 2'd1,
        REG_SIZE_SPREAD = 2'd2
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT_REQ,
        S_EMIT_WAIT,
        S_EMIT_MUL,
        S_EMIT_ADD,
        S_EMIT_WR,
        S_TICK_ANG,
        S_SCAN,
        S_TICK_MX,
        S_TICK_MY,
        S_TICK_WR,
        S_REN_Q,
        S_REN_DIV,
        S_REN_MIX,
        S_REN_OUT
    } t_state;

    typedef enum logic [2:0] {
        TW_SEED_WR,
        TW_SEED_MUL,
        TW_IDLE,
        TW_RD0,
        TW_RD1,
        TW_RD2,
        TW_GEN
    } t_tw_state;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [15:0] angle;
        logic [31:0] color_birth;
        logic [31:0] color_death;
        logic [31:0] life_total;
        logic [31:0] life_left;
        logic [15:0] size_birth;
        logic [15:0] size_death;
    } t_particle;

    typedef struct packed {
        logic in_ready;
        logic tw_req;
        logic ram_re;
        logic ram_we;
        logic div_start;
        logic advance;
        logic out_load;
    } t_ctrl;

    function automatic logic [31:0] f_sat32(input logic signed [49:0] v);
        logic [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] f_temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & 32'h9D2C_5680);
        y = y ^ ((y << 15) & 32'hEFC6_0000);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== sv/ppu_pool_ram.sv =====
module ppu_pool_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 304,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic                  i_re,
    input  logic [ADDR_W-1:0]     i_addr,
    input  logic [WIDTH-1:0]      i_wdata,
    output logic [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== sv/ppu_twister.sv =====
module ppu_twister (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req,
    output logic        o_ready,
    output logic        o_valid,
    output logic [23:0] o_rand
);
    ppu_pkg::t_tw_state r_state, n_state;

    logic [31:0] r_mem [ppu_pkg::TW_N];
    logic [31:0] r_q;
    logic [9:0]  r_k;
    logic [9:0]  r_i;
    logic [31:0] r_word;
    logic [31:0] r_wi;
    logic [31:0] r_wi1;
    logic        r_valid;
    logic [23:0] r_rand;

    logic [9:0]  w_i1, w_im, w_addr;
    logic        w_we, w_re;
    logic [31:0] w_wdata, w_y, w_new, w_seed, w_temp;

    // words regenerate lazily, one per draw; neighbor reads see the same
    // old/new mix as a full in-place regeneration
    assign w_i1 = (r_i == ppu_pkg::TW_LAST) ? 10'd0 : r_i + 10'd1;
    assign w_im = (r_i >= ppu_pkg::TW_WRAP) ? r_i - ppu_pkg::TW_WRAP : r_i + ppu_pkg::TW_STEP;
    assign w_y  = (r_wi & 32'h8000_0000) | (r_wi1 & 32'h7FFF_FFFF);
    assign w_new = r_q ^ (w_y >> 1) ^ (w_y[0] ? ppu_pkg::TW_MAG : 32'h0);
    assign w_seed = r_word + {22'd0, r_k};
    assign w_temp = ppu_pkg::f_temper(w_new);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppu_pkg::TW_SEED_WR:  n_state = (r_k == ppu_pkg::TW_LAST) ? ppu_pkg::TW_IDLE
                                                                       : ppu_pkg::TW_SEED_MUL;
            ppu_pkg::TW_SEED_MUL: n_state = ppu_pkg::TW_SEED_WR;
            ppu_pkg::TW_IDLE:     n_state = i_req ? ppu_pkg::TW_RD0 : ppu_pkg::TW_IDLE;
            ppu_pkg::TW_RD0:      n_state = ppu_pkg::TW_RD1;
            ppu_pkg::TW_RD1:      n_state = ppu_pkg::TW_RD2;
            ppu_pkg::TW_RD2:      n_state = ppu_pkg::TW_GEN;
            ppu_pkg::TW_GEN:      n_state = ppu_pkg::TW_IDLE;
            default:              n_state = ppu_pkg::TW_IDLE;
        endcase
    end

    always_comb begin
        w_we = 1'b0;
        w_re = 1'b0;
        w_addr = r_i;
        w_wdata = w_new;
        unique case (r_state)
            ppu_pkg::TW_SEED_WR: begin
                w_we = 1'b1;
                w_addr = r_k;
                w_wdata = w_seed;
            end
            ppu_pkg::TW_RD0: w_re = 1'b1;
            ppu_pkg::TW_RD1: begin
                w_re = 1'b1;
                w_addr = w_i1;
            end
            ppu_pkg::TW_RD2: begin
                w_re = 1'b1;
                w_addr = w_im;
            end
            ppu_pkg::TW_GEN: w_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (w_re) begin
            r_q <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppu_pkg::TW_SEED_WR;
            r_k <= 10'd0;
            r_i <= 10'd0;
            r_word <= ppu_pkg::TW_SEED;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            unique case (r_state)
                ppu_pkg::TW_SEED_WR: r_word <= w_seed;
                ppu_pkg::TW_SEED_MUL: begin
                    r_word <= ppu_pkg::TW_MULT * (r_word ^ (r_word >> 30));
                    r_k <= r_k + 10'd1;
                end
                ppu_pkg::TW_RD1: r_wi <= r_q;
                ppu_pkg::TW_RD2: r_wi1 <= r_q;
                ppu_pkg::TW_GEN: begin
                    r_rand <= w_temp[31:8];
                    r_valid <= 1'b1;
                    r_i <= w_i1;
                end
                default: ;
            endcase
        end
    end

    assign o_ready = (r_state == ppu_pkg::TW_IDLE);
    assign o_valid = r_valid;
    assign o_rand  = r_rand;

endmodule

// ===== sv/ppu_div.sv =====
module ppu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [15:0] o_quot
);
    // restoring division, one quotient bit a cycle; needs num < den
    logic        r_busy, r_done;
    logic [3:0]  r_cnt;
    logic [31:0] r_rem, r_den;
    logic [15:0] r_quot;
    logic [32:0] w_t, w_diff;
    logic        w_ge;

    assign w_t = {r_rem, 1'b0};
    assign w_ge = (w_t >= {1'b0, r_den});
    assign w_diff = w_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 4'd0;
                r_rem <= i_num;
                r_den <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[31:0] : w_t[31:0];
                r_quot <= {r_quot[14:0], w_ge};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/particle_pool_update.sv =====
// channel   | dir | handshake                     | contents
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: fields, tuser: mode
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: readout, tlast: last
// apb       | in  | psel & penable & pwrite       | spread registers at 0x0/0x4/0x8
//
// Emit: four twister draws plus multiply/add per offset, then the pool write.
// Tick: an angle step, then dead slots are passed over; per surviving live slot a pool
// RAM read, two multiplies and a write back; a retired slot is cleared after its read.
// Render: per live slot a RAM read, the divider, mixes of the colour bytes, alpha and size.
// After reset the twister table is seeded; no item is taken until seeding is done.
// Output is registered; a stalled m_axis holds the walk at the current slot.
module particle_pool_update #(
    parameter int POOL_SIZE = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, color_start, color_finish,
    // size_start, size_finish, time_value
    input  logic [255:0]  s_axis_tdata,
    // mode
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_x, out_y, out_angle, out_size, out_color, out_slot, 2 bits pad
    output logic [135:0]  m_axis_tdata,
    output logic          m_axis_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    localparam int SLOT_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [SLOT_W-1:0] SLOT_END = SLOT_W'(POOL_SIZE - 1);
    localparam int REC_W = $bits(ppu_pkg::t_particle);

    ppu_pkg::t_state r_state, n_state;
    ppu_pkg::t_ctrl  w_ctl;

    logic [31:0] r_spread_x, r_spread_y;
    logic [15:0] r_size_spread;

    logic [POOL_SIZE-1:0] r_alive;
    logic [SLOT_W-1:0]    r_wslot, r_idx;

    logic [1:0]  r_mode;
    logic [31:0] r_in_px, r_in_py, r_in_vx, r_in_vy, r_in_cs, r_in_cf, r_tv;
    logic [15:0] r_in_ss, r_in_sf;

    logic [1:0]  r_draw;
    logic [23:0] r_rand;
    logic signed [57:0] r_eprod;
    logic [15:0] r_new_ang, r_new_size, r_ang_inc;
    logic [31:0] r_new_vx, r_new_vy, r_new_px;
    logic signed [64:0] r_mprod;

    logic [16:0] r_q;
    logic [2:0]  r_step;
    logic [7:0]  r_amix;
    logic [31:0] r_col;
    logic [15:0] r_rsize;

    logic         r_out_valid, r_out_last;
    logic [135:0] r_out_data;

    logic            tw_ready, tw_valid;
    logic [23:0]     tw_rand;
    logic            div_busy, div_done;
    logic [15:0]     div_quot;
    ppu_pkg::t_particle w_rec, w_wrec;
    logic [REC_W-1:0]   w_rdata;
    logic [SLOT_W-1:0]  w_ram_addr;

    logic w_accept, w_cfg_wr, w_end, w_retire, w_full, w_out_free, w_last;
    logic signed [24:0] w_c;
    logic [31:0]        w_spread;
    logic signed [33:0] w_off;
    logic signed [49:0] w_vsum, w_pxsum, w_pysum;
    logic signed [35:0] w_ssum;
    logic [63:0]        w_ang_prod;
    logic [15:0]        w_base, w_st;
    logic signed [16:0] w_sd;
    logic signed [34:0] w_mixv;
    logic [15:0]        w_mix;
    logic [POOL_SIZE-1:0] w_hi;

    ppu_twister u_twister (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ctl.tw_req),
        .o_ready (tw_ready),
        .o_valid (tw_valid),
        .o_rand  (tw_rand)
    );

    ppu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.div_start),
        .i_num   (w_rec.life_left),
        .i_den   (w_rec.life_total),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    ppu_pool_ram #(
        .DEPTH (POOL_SIZE),
        .WIDTH (REC_W)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (w_ctl.ram_we),
        .i_re    (w_ctl.ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_wrec),
        .o_rdata (w_rdata)
    );

    assign w_rec = ppu_pkg::t_particle'(w_rdata);

    // config port
    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            ppu_pkg::REG_SPREAD_X:    prdata = r_spread_x;
            ppu_pkg::REG_SPREAD_Y:    prdata = r_spread_y;
            ppu_pkg::REG_SIZE_SPREAD: prdata = {16'd0, r_size_spread};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spread_x <= 32'd0;
            r_spread_y <= 32'd0;
            r_size_spread <= 16'd0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                ppu_pkg::REG_SPREAD_X:    r_spread_x <= pwdata;
                ppu_pkg::REG_SPREAD_Y:    r_spread_y <= pwdata;
                ppu_pkg::REG_SIZE_SPREAD: r_size_spread <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // datapath terms
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_end = (r_idx == SLOT_END);
    assign w_retire = (r_tv >= w_rec.life_left);
    assign w_full = (w_rec.life_total == 32'd0) || (w_rec.life_left >= w_rec.life_total);
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_hi = r_alive >> r_idx;
    assign w_last = ~|(w_hi >> 1);

    assign w_c = $signed({1'b0, r_rand}) - 25'sd8388608;
    always_comb begin
        unique case (r_draw)
            2'd1:    w_spread = r_spread_x;
            2'd2:    w_spread = r_spread_y;
            default: w_spread = {16'd0, r_size_spread};
        endcase
    end
    assign w_off  = r_eprod[57:24];
    assign w_vsum = (r_draw == 2'd1 ? {{18{r_in_vx[31]}}, r_in_vx} : {{18{r_in_vy[31]}}, r_in_vy})
                    + {{16{w_off[33]}}, w_off};
    assign w_ssum = {20'd0, r_in_ss} + {{2{w_off[33]}}, w_off};

    assign w_ang_prod = {32'd0, r_tv} * {32'd0, ppu_pkg::TURN_PER_TIME};
    assign w_pxsum = {{18{w_rec.pos_x[31]}}, w_rec.pos_x} + {r_mprod[64], r_mprod[64:16]};
    assign w_pysum = {{18{w_rec.pos_y[31]}}, w_rec.pos_y} + {r_mprod[64], r_mprod[64:16]};

    // one mix per cycle: (fin*2^16 + (st - fin)*q + half) >> 16; alpha reuses it
    always_comb begin
        w_base = 16'd0;
        w_st = 16'd0;
        unique case (r_step)
            3'd0: begin
                w_base = {8'd0, w_rec.color_death[31:24]};
                w_st   = {8'd0, w_rec.color_birth[31:24]};
            end
            3'd1: begin
                w_base = {8'd0, w_rec.color_death[23:16]};
                w_st   = {8'd0, w_rec.color_birth[23:16]};
            end
            3'd2: begin
                w_base = {8'd0, w_rec.color_death[15:8]};
                w_st   = {8'd0, w_rec.color_birth[15:8]};
            end
            3'd3: begin
                w_base = {8'd0, w_rec.color_death[7:0]};
                w_st   = {8'd0, w_rec.color_birth[7:0]};
            end
            3'd4: begin
                w_base = 16'd0;
                w_st   = {8'd0, r_amix};
            end
            default: begin
                w_base = w_rec.size_death;
                w_st   = w_rec.size_birth;
            end
        endcase
    end
    assign w_sd = $signed({1'b0, w_st}) - $signed({1'b0, w_base});
    assign w_mixv = $signed({3'd0, w_base, 16'd0}) + w_sd * $signed({1'b0, r_q})
                    + 35'sd32768;
    assign w_mix = w_mixv[31:16];

    assign w_ram_addr = (r_state == ppu_pkg::S_EMIT_WR) ? r_wslot : r_idx;

    always_comb begin
        w_wrec = w_rec;
        if (r_state == ppu_pkg::S_EMIT_WR) begin
            w_wrec.pos_x       = r_in_px;
            w_wrec.pos_y       = r_in_py;
            w_wrec.vel_x       = r_new_vx;
            w_wrec.vel_y       = r_new_vy;
            w_wrec.angle       = r_new_ang;
            w_wrec.color_birth = r_in_cs;
            w_wrec.color_death = r_in_cf;
            w_wrec.life_total  = r_tv;
            w_wrec.life_left   = r_tv;
            w_wrec.size_birth  = r_new_size;
            w_wrec.size_death  = r_in_sf;
        end else begin
            w_wrec.pos_x     = r_new_px;
            w_wrec.pos_y     = ppu_pkg::f_sat32(w_pysum);
            w_wrec.life_left = w_rec.life_left - r_tv;
            w_wrec.angle     = w_rec.angle + r_ang_inc;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppu_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == ppu_pkg::MODE_EMIT) begin
                        n_state = ppu_pkg::S_EMIT_REQ;
                    end else if (s_axis_tuser == ppu_pkg::MODE_TICK) begin
                        n_state = ppu_pkg::S_TICK_ANG;
                    end else if (s_axis_tuser == ppu_pkg::MODE_RENDER) begin
                        n_state = ppu_pkg::S_SCAN;
                    end
                end
            end
            ppu_pkg::S_EMIT_REQ:  if (tw_ready) n_state = ppu_pkg::S_EMIT_WAIT;
            ppu_pkg::S_EMIT_WAIT: begin
                if (tw_valid) begin
                    n_state = (r_draw == 2'd0) ? ppu_pkg::S_EMIT_REQ : ppu_pkg::S_EMIT_MUL;
                end
            end
            ppu_pkg::S_EMIT_MUL: n_state = ppu_pkg::S_EMIT_ADD;
            ppu_pkg::S_EMIT_ADD: begin
                n_state = (r_draw == 2'd3) ? ppu_pkg::S_EMIT_WR : ppu_pkg::S_EMIT_REQ;
            end
            ppu_pkg::S_EMIT_WR:  n_state = ppu_pkg::S_IDLE;
            ppu_pkg::S_TICK_ANG: n_state = ppu_pkg::S_SCAN;
            ppu_pkg::S_SCAN: begin
                if (r_alive[r_idx]) begin
                    n_state = (r_mode == ppu_pkg::MODE_TICK) ? ppu_pkg::S_TICK_MX
                                                             : ppu_pkg::S_REN_Q;
                end else if (w_end) begin
                    n_state = ppu_pkg::S_IDLE;
                end
            end
            ppu_pkg::S_TICK_MX: begin
                if (w_retire) begin
                    n_state = w_end ? ppu_pkg::S_IDLE : ppu_pkg::S_SCAN;
                end else begin
                    n_state = ppu_pkg::S_TICK_MY;
                end
            end
            ppu_pkg::S_TICK_MY: n_state = ppu_pkg::S_TICK_WR;
            ppu_pkg::S_TICK_WR: n_state = w_end ? ppu_pkg::S_IDLE : ppu_pkg::S_SCAN;
            ppu_pkg::S_REN_Q:   n_state = w_full ? ppu_pkg::S_REN_MIX : ppu_pkg::S_REN_DIV;
            ppu_pkg::S_REN_DIV: if (div_done) n_state = ppu_pkg::S_REN_MIX;
            ppu_pkg::S_REN_MIX: if (r_step == ppu_pkg::MIX_LAST) n_state = ppu_pkg::S_REN_OUT;
            ppu_pkg::S_REN_OUT: begin
                if (w_out_free) begin
                    n_state = w_end ? ppu_pkg::S_IDLE : ppu_pkg::S_SCAN;
                end
            end
            default: n_state = ppu_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            ppu_pkg::S_IDLE:     w_ctl.in_ready = tw_ready;
            ppu_pkg::S_EMIT_REQ: w_ctl.tw_req = tw_ready;
            ppu_pkg::S_EMIT_WR:  w_ctl.ram_we = 1'b1;
            ppu_pkg::S_SCAN: begin
                w_ctl.ram_re = r_alive[r_idx];
                w_ctl.advance = !r_alive[r_idx] && !w_end;
            end
            ppu_pkg::S_TICK_MX: w_ctl.advance = w_retire && !w_end;
            ppu_pkg::S_TICK_WR: begin
                w_ctl.ram_we = 1'b1;
                w_ctl.advance = !w_end;
            end
            ppu_pkg::S_REN_Q:   w_ctl.div_start = !w_full;
            ppu_pkg::S_REN_OUT: begin
                w_ctl.out_load = w_out_free;
                w_ctl.advance = w_out_free && !w_end;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppu_pkg::S_IDLE;
            r_alive <= '0;
            r_wslot <= '0;
            r_idx <= '0;
            r_draw <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.advance) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ppu_pkg::S_IDLE: begin
                    r_idx <= '0;
                    r_draw <= 2'd0;
                end
                ppu_pkg::S_EMIT_WAIT: if (tw_valid && r_draw == 2'd0) r_draw <= 2'd1;
                ppu_pkg::S_EMIT_ADD:  r_draw <= r_draw + 2'd1;
                ppu_pkg::S_EMIT_WR: begin
                    r_alive[r_wslot] <= 1'b1;
                    r_wslot <= (r_wslot == SLOT_END) ? '0 : r_wslot + 1'b1;
                end
                ppu_pkg::S_TICK_MX: if (w_retire) r_alive[r_idx] <= 1'b0;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= s_axis_tuser;
            r_in_px <= s_axis_tdata[31:0];
            r_in_py <= s_axis_tdata[63:32];
            r_in_vx <= s_axis_tdata[95:64];
            r_in_vy <= s_axis_tdata[127:96];
            r_in_cs <= s_axis_tdata[159:128];
            r_in_cf <= s_axis_tdata[191:160];
            r_in_ss <= s_axis_tdata[207:192];
            r_in_sf <= s_axis_tdata[223:208];
            r_tv    <= s_axis_tdata[255:224];
        end
        if (tw_valid) begin
            r_rand <= tw_rand;
            if (r_draw == 2'd0) begin
                r_new_ang <= tw_rand[23:8];
            end
        end
        if (w_ctl.out_load) begin
            r_out_data <= {2'b00, 6'(r_idx), r_col, r_rsize, w_rec.angle,
                           w_rec.pos_y, w_rec.pos_x};
            r_out_last <= w_last;
        end
        unique case (r_state)
            ppu_pkg::S_EMIT_MUL: r_eprod <= $signed({1'b0, w_spread}) * w_c;
            ppu_pkg::S_EMIT_ADD: begin
                if (r_draw == 2'd1) begin
                    r_new_vx <= ppu_pkg::f_sat32(w_vsum);
                end else if (r_draw == 2'd2) begin
                    r_new_vy <= ppu_pkg::f_sat32(w_vsum);
                end else if (w_ssum < 36'sd0) begin
                    r_new_size <= 16'd0;
                end else if (w_ssum > 36'sd65535) begin
                    r_new_size <= 16'hFFFF;
                end else begin
                    r_new_size <= w_ssum[15:0];
                end
            end
            ppu_pkg::S_TICK_ANG: r_ang_inc <= w_ang_prod[47:32];
            ppu_pkg::S_TICK_MX:  r_mprod <= $signed(w_rec.vel_x) * $signed({1'b0, r_tv});
            ppu_pkg::S_TICK_MY: begin
                r_new_px <= ppu_pkg::f_sat32(w_pxsum);
                r_mprod <= $signed(w_rec.vel_y) * $signed({1'b0, r_tv});
            end
            ppu_pkg::S_REN_Q: begin
                r_step <= 3'd0;
                if (w_full) begin
                    r_q <= ppu_pkg::Q_ONE;
                end
            end
            ppu_pkg::S_REN_DIV: if (div_done) r_q <= {1'b0, div_quot};
            ppu_pkg::S_REN_MIX: begin
                r_step <= r_step + 3'd1;
                unique case (r_step)
                    3'd0:    r_col[31:24] <= w_mix[7:0];
                    3'd1:    r_col[23:16] <= w_mix[7:0];
                    3'd2:    r_col[15:8]  <= w_mix[7:0];
                    3'd3:    r_amix       <= w_mix[7:0];
                    3'd4:    r_col[7:0]   <= w_mix[7:0];
                    default: r_rsize      <= w_mix;
                endcase
            end
            default: ;
        endcase
    end

    assign s_axis_tready = w_ctl.in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_tw_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.tw_req |-> tw_ready)
        else $error("twister request while busy");

    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppu_pkg::S_REN_MIX && r_q[16]) |-> (r_q[15:0] == 16'd0))
        else $error("life ratio above one");

    a_emit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppu_pkg::S_EMIT_WR) |=> r_alive[$past(r_wslot)])
        else $error("emitted slot not live");

endmodule
